// File: design/ntcb_pkg.sv
// Shared types, widths and constants of the NTC thermistor Beta temperature block.
package ntcb_pkg;

  // Port and state widths.
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 6;
  localparam int TEMP_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int BETA_W     = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // Parameter defaults.
  localparam int SAMPLES_DEF    = 16;
  localparam int FULL_SCALE_DEF = 3300;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_INV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 1'd1;
  localparam logic [BETA_W-1:0]    BETA_RESET  = 14'd3950;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  // Output temperature limits in hundredths of a degree Celsius.
  localparam int TEMP_LOW_I  = -5500;
  localparam int TEMP_HIGH_I = 25000;

  // Shared multiplier.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Fixed-point logarithm: mantissa in Q30, result in Q24.
  localparam int FRAC_W = 24;
  localparam int M_W    = 31;
  localparam int EXP_W  = 5;
  localparam int LOG_W  = EXP_W + FRAC_W;
  localparam int RND_W  = 5;

  // ln 2 in Q30, T0 in hundredths of a kelvin, 100 * T0 * 100 as one factor.
  localparam logic [MUL_W-1:0] LN2_Q30      = 32'd744261118;
  localparam logic [MUL_W-1:0] T0_CENTI     = 32'd29815;
  localparam logic [MUL_W-1:0] BETA_NUMER_K = 32'd2981500;
  localparam int               KELVIN_OFS   = 27315;

  // Divider geometry: quotient is bounded, larger values saturate anyway.
  localparam int DIVIDEND_W = 61;
  localparam int DIVISOR_W  = 46;
  localparam int QUOT_W     = 17;
  localparam int QCNT_W     = $clog2(QUOT_W);

  // Divider result back to the sequencer.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

// File: design/ntcb_mul.sv
// Shared unsigned multiplier with a registered product.
module ntcb_mul (
  input  logic                         clk,
  input  logic [ntcb_pkg::MUL_W-1:0]   mul_a,
  input  logic [ntcb_pkg::MUL_W-1:0]   mul_b,
  output logic [ntcb_pkg::PROD_W-1:0]  prod_r
);

  // Product is available in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= ntcb_pkg::PROD_W'(mul_a) * ntcb_pkg::PROD_W'(mul_b);
  end

endmodule

// File: design/ntcb_div.sv
// Restoring divider, one quotient bit a cycle, with an overflow flag for large quotients.
module ntcb_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ntcb_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [ntcb_pkg::DIVISOR_W-1:0]    divisor,
  output ntcb_pkg::div_res_t                res
);

  localparam int QW   = ntcb_pkg::QUOT_W;
  localparam int NW   = ntcb_pkg::DIVIDEND_W;
  localparam int DW   = ntcb_pkg::DIVISOR_W;
  localparam int SHW  = DW + QW - 1;
  localparam int OVW  = DW + QW;

  logic                        run_r;
  logic                        done_r;
  logic                        ovf_r;
  logic [ntcb_pkg::QCNT_W-1:0] cnt_r;
  logic [NW-1:0]               rem_r;
  logic [SHW-1:0]              dsh_r;
  logic [QW-1:0]               q_r;
  logic                        too_big;
  logic                        fits;

  // The quotient overflows its width when the dividend reaches divisor * 2^QW.
  assign too_big = OVW'(dividend) >= {divisor, {QW{1'b0}}};
  assign fits    = SHW'(rem_r) >= dsh_r;

  // Control: run flag, done pulse, overflow flag and bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ovf_r <= too_big;
        if (too_big) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
          cnt_r <= ntcb_pkg::QCNT_W'(QW - 1);
        end
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: compare, subtract and shift the divisor down one place a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {divisor, {(QW - 1){1'b0}}};
      q_r   <= '0;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= rem_r - NW'(dsh_r);
      end
      q_r   <= {q_r[QW-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;

endmodule

// File: design/ntc_thermistor_beta_temperature.sv
// Top level: sample averaging, Beta-equation sequencer and result register.
//
// Samples are summed in groups of SAMPLES; a sample that does not close a group
// leaves in_ready high for the next one. The sample that closes a group starts the
// temperature calculation, which holds in_ready low until the result has passed to
// the output register: two base-2 logarithms, each of one set-up step and 24 squaring
// rounds through the shared 32x32 multiplier, three further products, a 17-step
// restoring divider and a last state that passes the result on. A non-positive
// denominator skips the divider, and a quotient too large for the divider makes it
// report done with its overflow flag set, without running. A group whose mean is
// zero or not below full scale goes straight to that last state with status 1.
// The result sits in an output register, so new samples are accepted while it waits
// to be taken; only the next calculation waits for the register to be free.
module ntc_thermistor_beta_temperature #(
  parameter int SAMPLES       = ntcb_pkg::SAMPLES_DEF,
  parameter int FULL_SCALE_MV = ntcb_pkg::FULL_SCALE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ntcb_pkg::SAMPLE_W-1:0]      in_sample_mv,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ntcb_pkg::TEMP_W-1:0] out_temp_centi_c,
  output logic [ntcb_pkg::STATUS_W-1:0]      out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ntcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ntcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW    = ntcb_pkg::SUM_W;
  localparam int CW    = ntcb_pkg::CNT_W;
  localparam int MW    = ntcb_pkg::M_W;
  localparam int EW    = ntcb_pkg::EXP_W;
  localparam int FW    = ntcb_pkg::FRAC_W;
  localparam int LW    = ntcb_pkg::LOG_W;
  localparam int PW    = ntcb_pkg::PROD_W;
  localparam int UW    = ntcb_pkg::MUL_W;
  localparam int BW    = ntcb_pkg::BETA_W;
  localparam int TW    = ntcb_pkg::TEMP_W;
  localparam int NW    = ntcb_pkg::DIVIDEND_W;
  localparam int DW    = ntcb_pkg::DIVISOR_W;
  localparam int QW    = ntcb_pkg::QUOT_W;
  localparam int B100W = 21;
  localparam int BTW   = B100W + FW;
  localparam int TPW   = 44;
  localparam int DSW   = DW + 1;
  localparam int NUMW  = 36;
  localparam int TXW   = QW + 1;

  localparam logic [SW-1:0] FULL = SW'(FULL_SCALE_MV * SAMPLES);
  localparam logic signed [TXW-1:0] T_LO  = TXW'(ntcb_pkg::TEMP_LOW_I);
  localparam logic signed [TXW-1:0] T_HI  = TXW'(ntcb_pkg::TEMP_HIGH_I);
  localparam logic signed [TXW-1:0] K_OFS = TXW'(ntcb_pkg::KELVIN_OFS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOG_INIT = 4'd1;
  localparam logic [3:0] S_LOG_SQ   = 4'd2;
  localparam logic [3:0] S_LOG_UPD  = 4'd3;
  localparam logic [3:0] S_LN_MUL   = 4'd4;
  localparam logic [3:0] S_LN_RES   = 4'd5;
  localparam logic [3:0] S_D_MUL    = 4'd6;
  localparam logic [3:0] S_D_RES    = 4'd7;
  localparam logic [3:0] S_N_MUL    = 4'd8;
  localparam logic [3:0] S_N_RES    = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]                state_r, state_nxt;
  logic                      div_inv_r;
  logic [BW-1:0]             beta_r;
  logic [SW-1:0]             sum_r;
  logic [CW-1:0]             cnt_r;
  logic [SW-1:0]             grp_r;
  logic                      phase_r;
  logic [MW-1:0]             m_r;
  logic [EW-1:0]             exp_r;
  logic [FW-1:0]             frac_r;
  logic [ntcb_pkg::RND_W-1:0] rnd_r;
  logic [LW-1:0]             lnum_r;
  logic [LW-1:0]             lden_r;
  logic                      dneg_r;
  logic [LW-1:0]             lmag_r;
  logic [DW-1:0]             dd_r;
  logic signed [TW-1:0]      res_temp_r;
  logic [ntcb_pkg::STATUS_W-1:0] res_status_r;
  logic                      out_valid_r;
  logic signed [TW-1:0]      out_temp_r;
  logic [ntcb_pkg::STATUS_W-1:0] out_status_r;

  logic                      accept;
  logic [SW-1:0]             sum_add;
  logic [CW:0]               cnt_inc;
  logic                      last;
  logic                      bad_mean;
  logic [SW-1:0]             num_v;
  logic [SW-1:0]             den_v;
  logic [SW-1:0]             log_x;
  logic [EW-1:0]             msb;
  logic [MW-1:0]             m_init;
  logic [UW-1:0]             mul_a;
  logic [UW-1:0]             mul_b;
  logic [PW-1:0]             prod;
  logic [UW-1:0]             sq;
  logic [MW-1:0]             m_upd;
  logic [FW-1:0]             frac_nxt;
  logic signed [LW:0]        dlog;
  logic [LW-1:0]             mag;
  logic [PW-5:0]             ln_round;
  logic [B100W-1:0]          b100;
  logic [BTW-1:0]            bterm;
  logic signed [DSW-1:0]     dsum;
  logic                      dpos;
  logic [NW-1:0]             dividend;
  logic                      div_start;
  ntcb_pkg::div_res_t        div_res;
  logic signed [TXW-1:0]     t_c;
  logic                      out_free;

  // Handshakes.
  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Group accumulation and the range check of the closing sum.
  assign sum_add  = sum_r + SW'(in_sample_mv);
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign last     = !(cnt_inc < (CW + 1)'(SAMPLES));
  assign bad_mean = (sum_add == '0) || (sum_add >= FULL);

  // Resistance ratio operands.
  assign num_v = div_inv_r ? (FULL - grp_r) : grp_r;
  assign den_v = div_inv_r ? grp_r : (FULL - grp_r);
  assign log_x = phase_r ? den_v : num_v;

  // Leading one of the log operand and the Q30 mantissa.
  always_comb begin
    msb = '0;
    for (int i = 0; i < SW; i++) begin
      if (log_x[i]) begin
        msb = EW'(i);
      end
    end
  end
  assign m_init = MW'(log_x) << (EW'(MW - 1) - msb);

  // Squaring round: keep the mantissa in [1,2) and collect one fraction bit.
  assign sq       = prod[2*(MW-1)+1:MW-1];
  assign m_upd    = sq[UW-1] ? sq[UW-1:1] : sq[MW-1:0];
  assign frac_nxt = frac_r | (FW'(sq[UW-1]) << rnd_r);

  // ln of the ratio from the two logarithms.
  assign dlog     = $signed({1'b0, lnum_r}) - $signed({1'b0, lden_r});
  assign mag      = dlog[LW] ? LW'(-dlog) : LW'(dlog);
  assign ln_round = prod[PW-5:0] + (PW - 4)'(64'd1 << 29);

  // Denominator 100*B*2^24 +/- 29815*|ln| and the rounded numerator.
  assign b100     = B100W'(beta_r) * B100W'(100);
  assign bterm    = {b100, {FW{1'b0}}};
  assign dsum     = dneg_r ? ($signed(DSW'(bterm)) - $signed(DSW'(prod[TPW-1:0])))
                           : ($signed(DSW'(bterm)) + $signed(DSW'(prod[TPW-1:0])));
  assign dpos     = !dsum[DSW-1] && (dsum != '0);
  assign dividend = {1'b0, prod[NUMW-1:0], {FW{1'b0}}} + NW'(dd_r >> 1);
  assign div_start = state_r == S_N_RES;

  // Kelvin to Celsius.
  assign t_c = $signed({1'b0, div_res.quot}) - K_OFS;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      S_LOG_SQ: begin
        mul_a = UW'(m_r);
        mul_b = UW'(m_r);
      end
      S_LN_MUL: begin
        mul_a = UW'(mag);
        mul_b = ntcb_pkg::LN2_Q30;
      end
      S_D_MUL: begin
        mul_a = UW'(lmag_r);
        mul_b = ntcb_pkg::T0_CENTI;
      end
      S_N_MUL: begin
        mul_a = UW'(beta_r);
        mul_b = ntcb_pkg::BETA_NUMER_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ntcb_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  ntcb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dd_r),
    .res      (div_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && last) begin
          state_nxt = bad_mean ? S_DONE : S_LOG_INIT;
        end
      end
      S_LOG_INIT: state_nxt = S_LOG_SQ;
      S_LOG_SQ:   state_nxt = S_LOG_UPD;
      S_LOG_UPD: begin
        if (rnd_r != '0) begin
          state_nxt = S_LOG_SQ;
        end else begin
          state_nxt = phase_r ? S_LN_MUL : S_LOG_INIT;
        end
      end
      S_LN_MUL:   state_nxt = S_LN_RES;
      S_LN_RES:   state_nxt = S_D_MUL;
      S_D_MUL:    state_nxt = S_D_RES;
      S_D_RES:    state_nxt = dpos ? S_N_MUL : S_DONE;
      S_N_MUL:    state_nxt = S_N_RES;
      S_N_RES:    state_nxt = S_DIV;
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control registers: state, configuration, accumulator, log phase and round counter, and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_inv_r   <= 1'b0;
      beta_r      <= ntcb_pkg::BETA_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          ntcb_pkg::CFG_DIV_INV: div_inv_r <= cfg_data[0];
          ntcb_pkg::CFG_BETA:    beta_r    <= cfg_data[BW-1:0];
          default:               ;
        endcase
      end
      if (accept) begin
        if (last) begin
          sum_r   <= '0;
          cnt_r   <= '0;
          phase_r <= 1'b0;
        end else begin
          sum_r <= sum_add;
          cnt_r <= cnt_inc[CW-1:0];
        end
      end
      if (state_r == S_LOG_INIT) begin
        rnd_r <= ntcb_pkg::RND_W'(FW - 1);
      end else if (state_r == S_LOG_UPD) begin
        if (rnd_r == '0) begin
          phase_r <= 1'b1;
        end else begin
          rnd_r <= rnd_r - 1'b1;
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && last) begin
      grp_r <= sum_add;
    end
    if (state_r == S_LOG_INIT) begin
      m_r    <= m_init;
      exp_r  <= msb;
      frac_r <= '0;
    end else if (state_r == S_LOG_UPD) begin
      m_r    <= m_upd;
      frac_r <= frac_nxt;
      if (rnd_r == '0) begin
        if (phase_r) begin
          lden_r <= {exp_r, frac_nxt};
        end else begin
          lnum_r <= {exp_r, frac_nxt};
        end
      end
    end
    if (state_r == S_LN_MUL) begin
      dneg_r <= dlog[LW];
    end
    if (state_r == S_LN_RES) begin
      lmag_r <= ln_round[LW+29:30];
    end
    if (state_r == S_D_RES) begin
      dd_r <= dsum[DW-1:0];
    end

    // Result of the calculation, saturated to the output range.
    if (state_r == S_IDLE && accept && last) begin
      res_temp_r   <= '0;
      res_status_r <= ntcb_pkg::ST_RANGE;
    end else if (state_r == S_D_RES && !dpos) begin
      res_temp_r   <= TW'(ntcb_pkg::TEMP_LOW_I);
      res_status_r <= ntcb_pkg::ST_SAT;
    end else if (state_r == S_DIV && div_res.done) begin
      if (div_res.ovf || t_c > T_HI) begin
        res_temp_r   <= TW'(ntcb_pkg::TEMP_HIGH_I);
        res_status_r <= ntcb_pkg::ST_SAT;
      end else if (t_c < T_LO) begin
        res_temp_r   <= TW'(ntcb_pkg::TEMP_LOW_I);
        res_status_r <= ntcb_pkg::ST_SAT;
      end else begin
        res_temp_r   <= t_c[TW-1:0];
        res_status_r <= ntcb_pkg::ST_OK;
      end
    end

    // Output register.
    if (state_r == S_DONE && out_free) begin
      out_temp_r   <= res_temp_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_centi_c = out_temp_r;
  assign out_status       = out_status_r;

endmodule

// File: design/ntcb_chk.sv
// Port-level checker for the thermistor temperature block, bound to the top level.
module ntcb_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ntcb_pkg::TEMP_W-1:0] out_temp_centi_c,
  input logic [ntcb_pkg::STATUS_W-1:0]      out_status
);

  localparam logic signed [ntcb_pkg::TEMP_W-1:0] T_LO = ntcb_pkg::TEMP_W'(ntcb_pkg::TEMP_LOW_I);
  localparam logic signed [ntcb_pkg::TEMP_W-1:0] T_HI = ntcb_pkg::TEMP_W'(ntcb_pkg::TEMP_HIGH_I);

  // An out-of-range mean carries a zero temperature.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ntcb_pkg::ST_RANGE |-> out_temp_centi_c == '0)
    else $error("out-of-range result with non-zero temperature");

  // A saturated result sits exactly on one of the limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ntcb_pkg::ST_SAT |->
      out_temp_centi_c == T_LO || out_temp_centi_c == T_HI)
    else $error("saturated result not on a limit");

  // The block only stops taking requests right after taking one.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in_ready dropped without an accepted request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_temp_centi_c) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind ntc_thermistor_beta_temperature ntcb_chk u_ntcb_chk (.*);

// File: bench/testbench.sv
// Self-checking testbench for the NTC thermistor Beta temperature block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUP_LEN     = 16;
  localparam int FULL_MV       = 3300;
  localparam int FULL_SUM      = FULL_MV * GROUP_LEN;
  localparam int MAX_MV        = 4095;
  localparam int SETTLE_CYCLES = 160;
  localparam int LIMIT_NS      = 4_000_000;

  // Fixed-point constants of the Beta equation.
  localparam longint unsigned LN2_FIX  = 64'd744261118;
  localparam longint unsigned HALF_Q30 = 64'd536870912;
  localparam longint          Q24_ONE  = 64'sd16777216;
  localparam longint          T0_CK    = 64'sd29815;
  localparam longint          ZERO_C   = 64'sd27315;
  localparam longint          TEMP_MIN = longint'(ntcb_pkg::TEMP_LOW_I);
  localparam longint          TEMP_MAX = longint'(ntcb_pkg::TEMP_HIGH_I);

  // Field extremes and alternating bit patterns for the first group.
  localparam logic [GROUP_LEN*ntcb_pkg::SAMPLE_W-1:0] EDGE_SAMPLES = {
    12'd0, 12'd4095, 12'd2730, 12'd1365, 12'd1, 12'd2048, 12'd4094, 12'd0,
    12'd3300, 12'd3299, 12'd1024, 12'd512, 12'd256, 12'd128, 12'd64, 12'd32};

  // Beta corners: both ends of the stated range, zero and the largest code.
  localparam logic [4*ntcb_pkg::BETA_W-1:0] BETA_CORNERS = {
    14'd1000, 14'd10000, 14'd0, 14'd16383};

  typedef struct {
    logic signed [ntcb_pkg::TEMP_W-1:0] temp;
    logic [ntcb_pkg::STATUS_W-1:0]      status;
  } reading_t;

  logic                                 clk;
  logic                                 rst_n        = 1'b0;
  logic                                 in_valid     = 1'b0;
  logic                                 in_ready;
  logic [ntcb_pkg::SAMPLE_W-1:0]        in_sample_mv = '0;
  logic                                 out_valid;
  logic                                 out_ready    = 1'b0;
  logic signed [ntcb_pkg::TEMP_W-1:0]   out_temp_centi_c;
  logic [ntcb_pkg::STATUS_W-1:0]        out_status;
  logic                                 cfg_valid    = 1'b0;
  logic                                 cfg_ready;
  logic [ntcb_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [ntcb_pkg::CFG_DATA_W-1:0]      cfg_data     = '0;

  // Mirror of the block's registers and accumulator.
  logic                                 inv_cfg   = 1'b0;
  logic [ntcb_pkg::BETA_W-1:0]          beta_cfg  = ntcb_pkg::BETA_RESET;
  logic [ntcb_pkg::SUM_W-1:0]           acc_sum   = '0;
  int                                   acc_count = 0;
  reading_t                             expected_readings[$];
  int                                   fail_count    = 0;
  bit                                   steady_sender = 1'b0;

  ntc_thermistor_beta_temperature #(
    .SAMPLES      (GROUP_LEN),
    .FULL_SCALE_MV(FULL_MV)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_mv    (in_sample_mv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temp_centi_c(out_temp_centi_c),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Base-2 logarithm in Q24 by repeated squaring of the Q30 mantissa.
  function automatic longint log2_fix(input int unsigned x);
    int              msb;
    longint unsigned mant;
    longint          frac_bits;
    msb = 0;
    frac_bits = 0;
    if (x == 0) return 0;
    for (int i = 0; i < 32; i++) if (x[i]) msb = i;
    if (msb <= 30) mant = longint'(x) << (30 - msb);
    else mant = longint'(x) >> (msb - 30);
    for (int i = ntcb_pkg::FRAC_W - 1; i >= 0; i--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac_bits = frac_bits | (longint'(1) << i);
      end
    end
    return (longint'(msb) << ntcb_pkg::FRAC_W) + frac_bits;
  endfunction

  // Temperature and status for one completed group sum.
  function automatic reading_t predict_temperature(input int total);
    reading_t        r;
    int              num;
    int              den;
    longint          diff;
    longint          lnq;
    longint          denom;
    longint          numer;
    longint          t;
    longint unsigned mag;
    r.temp = '0;
    r.status = ntcb_pkg::ST_OK;
    if (total == 0 || total >= FULL_SUM) begin
      r.status = ntcb_pkg::ST_RANGE;
      return r;
    end
    num = inv_cfg ? FULL_SUM - total : total;
    den = inv_cfg ? total : FULL_SUM - total;
    diff = log2_fix(num) - log2_fix(den);
    mag = (diff < 0) ? -diff : diff;
    mag = (mag * LN2_FIX + HALF_Q30) >> 30;
    lnq = (diff < 0) ? -longint'(mag) : longint'(mag);
    denom = 64'sd100 * longint'(beta_cfg) * Q24_ONE + T0_CK * lnq;
    if (denom <= 0) begin
      t = TEMP_MIN;
      r.status = ntcb_pkg::ST_SAT;
    end else begin
      numer = 64'sd100 * longint'(beta_cfg) * T0_CK * Q24_ONE;
      t = (numer + denom / 2) / denom - ZERO_C;
      if (t < TEMP_MIN) begin
        t = TEMP_MIN;
        r.status = ntcb_pkg::ST_SAT;
      end else if (t > TEMP_MAX) begin
        t = TEMP_MAX;
        r.status = ntcb_pkg::ST_SAT;
      end
    end
    r.temp = t[ntcb_pkg::TEMP_W-1:0];
    return r;
  endfunction

  // Add one accepted sample; a closing sample queues the expected reading.
  function automatic void take_sample(input logic [ntcb_pkg::SAMPLE_W-1:0] mv);
    int total;
    acc_sum = acc_sum + ntcb_pkg::SUM_W'(mv);
    if (acc_count + 1 < GROUP_LEN) begin
      acc_count++;
      return;
    end
    total = int'(acc_sum);
    acc_sum = '0;
    acc_count = 0;
    expected_readings.push_back(predict_temperature(total));
  endfunction

  // Requests are observed at the falling edge, where all handshake signals are
  // stable until the rising edge that completes the transfer.
  always @(negedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading temp %0d status %0d", $time,
                 out_temp_centi_c, out_status);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_temp_centi_c !== want.temp) begin
          $display("%0t: temperature expected %0d, got %0d", $time, want.temp,
                   out_temp_centi_c);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          fail_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) take_sample(in_sample_mv);
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == ntcb_pkg::CFG_DIV_INV) inv_cfg = cfg_data[0];
      else if (cfg_index == ntcb_pkg::CFG_BETA) beta_cfg = cfg_data[ntcb_pkg::BETA_W-1:0];
    end
  end

  // Receiver back-pressure: mostly short stalls, some long ones, free runs mostly short, some long.
  initial begin
    int hi;
    int lo;
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      hi = ($urandom_range(0, 99) < 20) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      lo = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(20, 150);
      repeat (hi) @(posedge clk);
      out_ready <= 1'b0;
      repeat (lo) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one sample request; valid stays high on return so that a following
  // request with no gap needs only one assignment per edge.
  task automatic send_sample(input logic [ntcb_pkg::SAMPLE_W-1:0] mv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_mv <= mv;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Write one configuration register while the block is idle.
  task automatic write_register(input logic [ntcb_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ntcb_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_divider(input bit inverted);
    logic [ntcb_pkg::CFG_DATA_W-1:0] word;
    word = ntcb_pkg::CFG_DATA_W'($urandom);
    word[0] = inverted;
    write_register(ntcb_pkg::CFG_DIV_INV, word);
  endtask

  // Stop sending and wait for every outstanding reading plus a calculation time.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A group whose samples add up to a chosen total.
  task automatic send_sum_group(input int total);
    int left;
    int lo;
    int hi;
    int avg;
    int mv;
    left = total;
    for (int i = 0; i < GROUP_LEN; i++) begin
      hi = (left < MAX_MV) ? left : MAX_MV;
      lo = left - MAX_MV * (GROUP_LEN - 1 - i);
      if (lo < 0) lo = 0;
      avg = left / (GROUP_LEN - i);
      if ($urandom_range(0, 1) == 0) begin
        if (avg - 64 > lo) lo = avg - 64;
        if (avg + 64 < hi) hi = avg + 64;
      end
      mv = $urandom_range(hi, lo);
      send_sample(ntcb_pkg::SAMPLE_W'(mv));
      left -= mv;
    end
  endtask

  // One group of random kind: free noise, a chosen sum, or the range edges.
  task automatic send_random_group();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      for (int i = 0; i < GROUP_LEN; i++)
        send_sample(ntcb_pkg::SAMPLE_W'($urandom_range(0, MAX_MV)));
    end else if (r < 62) send_sum_group($urandom_range(1, FULL_SUM - 1));
    else if (r < 72) send_sum_group($urandom_range(1, 200));
    else if (r < 82) send_sum_group($urandom_range(FULL_SUM - 200, FULL_SUM - 1));
    else if (r < 88) send_sum_group(0);
    else if (r < 94) send_sum_group(FULL_SUM);
    else send_sum_group($urandom_range(FULL_SUM + 1, MAX_MV * GROUP_LEN));
  endtask

  // Every bit of the sample field at both values, extremes included.
  task automatic test_field_extremes();
    for (int i = 0; i < GROUP_LEN; i++)
      send_sample(EDGE_SAMPLES[(GROUP_LEN - 1 - i) * ntcb_pkg::SAMPLE_W +: ntcb_pkg::SAMPLE_W]);
    settle();
  endtask

  // Reset configuration: zero mean, full scale, the two nearest valid sums and random groups.
  task automatic test_default_config();
    send_sum_group(0);
    send_sum_group(FULL_SUM);
    send_sum_group(FULL_SUM - 1);
    send_sum_group(1);
    for (int g = 0; g < 12; g++) send_random_group();
    settle();
  endtask

  task automatic test_divider_inverted();
    write_divider(1'b1);
    send_sum_group(1);
    send_sum_group(FULL_SUM - 1);
    for (int g = 0; g < 10; g++) send_random_group();
    settle();
  endtask

  // Beta at both range ends, at zero and at the largest code.
  task automatic test_beta_extremes();
    for (int k = 0; k < 4; k++) begin
      write_register(ntcb_pkg::CFG_BETA,
                     ntcb_pkg::CFG_DATA_W'(BETA_CORNERS[k * ntcb_pkg::BETA_W +: ntcb_pkg::BETA_W]));
      write_divider(1'($urandom_range(0, 1)));
      for (int g = 0; g < 6; g++) send_random_group();
      settle();
    end
  endtask

  // Random settings; every other phase sends without any gaps.
  task automatic test_random_config();
    for (int p = 0; p < 5; p++) begin
      steady_sender = p[0];
      if ($urandom_range(0, 3) == 0)
        write_register(ntcb_pkg::CFG_BETA, ntcb_pkg::CFG_DATA_W'($urandom));
      else
        write_register(ntcb_pkg::CFG_BETA, ntcb_pkg::CFG_DATA_W'($urandom_range(1000, 10000)));
      write_divider(1'($urandom_range(0, 1)));
      for (int g = 0; g < 5; g++) send_random_group();
      settle();
    end
    steady_sender = 1'b0;
    write_divider(1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_default_config();
    test_divider_inverted();
    test_beta_extremes();
    test_random_config();
    if (fail_count == 0) begin
      $display("ntc_thermistor_beta_temperature regression: pass");
    end else begin
      $display("ntc_thermistor_beta_temperature regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("ntc_thermistor_beta_temperature regression: fail");
    $finish;
  end

endmodule

// File: sim.f
design/ntcb_pkg.sv
design/ntcb_mul.sv
design/ntcb_div.sv
design/ntc_thermistor_beta_temperature.sv
design/ntcb_chk.sv
bench/testbench.sv
